### hdl/arc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types, constants and helpers for the address range coalescer.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_BITS   = 48;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int COUNT_BITS  = 16;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_DUMP = 1'b1;

    typedef logic [ADDR_BITS-1:0]   addr_t;
    typedef logic [TABLE_DEPTH-1:0] slot_vec_t;
    typedef logic [IDX_W-1:0]       slot_idx_t;
    typedef logic [COUNT_BITS-1:0]  count_t;

    // one queued request
    typedef struct packed {
        logic  kind;
        addr_t span_lo;
        addr_t span_hi;
    } item_t;

    // queue head as seen by the table engine
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_WRITE,
        ST_DUMP
    } eng_state_t;

    // isolate lowest set bit
    function automatic slot_vec_t low_onehot(input slot_vec_t v);
        low_onehot = v & (~v + slot_vec_t'(1));
    endfunction

    // index of lowest set bit, 0 when none
    function automatic slot_idx_t low_index(input slot_vec_t v);
        slot_idx_t idx;
        idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (v[i])
            begin
                idx = slot_idx_t'(i);
            end
        end
        low_index = idx;
    endfunction

endpackage
`default_nettype wire

### hdl/arc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arc_front
// Request intake: two-entry queue between the stream input and the table.
// ----------------------------------------------------------------------------
module arc_front
    import arc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    input  wire item_t in_item,
    output head_t     head,
    input  wire logic pop
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    logic       do_pop;

    assign s_axis_tready = (fill_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign do_pop        = pop && (fill_reg != 2'd0);

    assign head.valid = (fill_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

### hdl/arc_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arc_table
// Range table engine: associative match, write-back, dump walk, result reg.
// ----------------------------------------------------------------------------
module arc_table
    import arc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire head_t head,
    output logic      pop,
    input  wire logic report_on_dump,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic      out_has_range,
    output addr_t     out_begin,
    output addr_t     out_end,
    output logic      out_last,
    output count_t    out_count,
    output logic      out_full
);

    addr_t      start_reg [TABLE_DEPTH];
    addr_t      stop_reg  [TABLE_DEPTH];
    slot_vec_t  valid_reg, valid_next;
    slot_vec_t  linked_reg, linked_next;
    count_t     count_reg, count_next;

    eng_state_t state_reg, state_next;
    item_t      item_reg;

    // match results carried from MATCH to WRITE
    logic       nochange_reg, full_reg;
    slot_idx_t  s_idx_reg;
    addr_t      left_reg, right_reg;
    slot_vec_t  next_oh_reg;
    logic [1:0] merged_reg;

    logic       ovalid_reg;
    logic       ohas_reg, olast_reg, ofull_reg;
    addr_t      obegin_reg, oend_reg;

    logic       out_free;
    logic       latch_item, latch_match, do_write, do_dump_emit, do_dump_clear;

    // ---------------- associative match ----------------
    slot_vec_t  hit_sb, hit_lb, hit_se;
    slot_vec_t  oh_sb, oh_lb, oh_se;
    addr_t      stop_sb, start_lb, stop_se;
    logic       key_s, key_l, key_hit, next_hit;
    slot_vec_t  key_oh, free_vec;
    slot_idx_t  s_idx_c;
    logic       nochange_c, full_c;

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit_sb[i] = valid_reg[i] && (start_reg[i] == item_reg.span_lo);
            hit_lb[i] = valid_reg[i] && linked_reg[i]
                        && (stop_reg[i] == item_reg.span_lo);
            hit_se[i] = valid_reg[i] && (start_reg[i] == item_reg.span_hi);
        end
        oh_sb = low_onehot(hit_sb);
        oh_lb = low_onehot(hit_lb);
        oh_se = low_onehot(hit_se);
        stop_sb  = '0;
        start_lb = '0;
        stop_se  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            stop_sb  = stop_sb  | (oh_sb[i] ? stop_reg[i]  : '0);
            start_lb = start_lb | (oh_lb[i] ? start_reg[i] : '0);
            stop_se  = stop_se  | (oh_se[i] ? stop_reg[i]  : '0);
        end
        key_s    = |hit_sb;
        key_l    = !key_s && (|hit_lb);
        key_hit  = key_s || key_l;
        key_oh   = key_s ? oh_sb : (key_l ? oh_lb : '0);
        next_hit = |hit_se;
        free_vec = ~valid_reg | oh_se;
        // reuse the key slot unless the same add merges it away
        if (key_hit && ((key_oh & oh_se) == '0))
        begin
            s_idx_c = low_index(key_oh);
        end
        else
        begin
            s_idx_c = low_index(free_vec);
        end
        nochange_c = key_s && (stop_sb >= item_reg.span_hi);
        full_c     = !key_hit && !next_hit && (&valid_reg);
    end

    // ---------------- dump walk ----------------
    slot_vec_t dump_oh;
    addr_t     dump_begin, dump_end;
    logic      dump_any, dump_last;

    always_comb
    begin
        dump_oh    = low_onehot(valid_reg);
        dump_begin = '0;
        dump_end   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            dump_begin = dump_begin | (dump_oh[i] ? start_reg[i] : '0);
            dump_end   = dump_end   | (dump_oh[i] ? stop_reg[i]  : '0);
        end
        dump_any  = report_on_dump && (|valid_reg);
        dump_last = ((valid_reg & ~dump_oh) == '0);
    end

    assign out_free = !ovalid_reg || out_ready;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = (head.item.kind == KIND_DUMP) ? ST_DUMP : ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (out_free && (!dump_any || dump_last))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- control strobes ----------------
    always_comb
    begin
        latch_item    = 1'b0;
        latch_match   = 1'b0;
        do_write      = 1'b0;
        do_dump_emit  = 1'b0;
        do_dump_clear = 1'b0;
        unique case (state_reg)
            ST_IDLE:  latch_item  = head.valid;
            ST_MATCH: latch_match = 1'b1;
            ST_WRITE: do_write    = out_free;
            ST_DUMP:
            begin
                do_dump_emit  = out_free && dump_any;
                do_dump_clear = out_free && !dump_any;
            end
            default:  latch_item  = 1'b0;
        endcase
    end

    assign pop = latch_item;

    // ---------------- table update ----------------
    logic [COUNT_BITS+1:0] count_sum;

    always_comb
    begin
        valid_next  = valid_reg;
        linked_next = linked_reg;
        count_next  = count_reg;
        count_sum   = {2'b00, count_reg} + 18'd1 - {16'd0, merged_reg};
        if (do_write && !nochange_reg && !full_reg)
        begin
            valid_next  = valid_reg & ~next_oh_reg;
            linked_next = linked_reg & ~next_oh_reg;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (valid_next[i] && (stop_reg[i] == right_reg))
                begin
                    linked_next[i] = 1'b0;
                end
            end
            valid_next[s_idx_reg]  = 1'b1;
            linked_next[s_idx_reg] = 1'b1;
            priority if (count_sum[COUNT_BITS+1])
            begin
                count_next = '0;
            end
            else if (count_sum[COUNT_BITS])
            begin
                count_next = '1;
            end
            else
            begin
                count_next = count_sum[COUNT_BITS-1:0];
            end
        end
        else if (do_dump_emit)
        begin
            valid_next  = valid_reg & ~dump_oh;
            linked_next = linked_reg & ~dump_oh;
        end
        else if (do_dump_clear)
        begin
            valid_next  = '0;
            linked_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            linked_reg <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            linked_reg <= linked_next;
            count_reg  <= count_next;
            if (do_write || do_dump_emit || do_dump_clear)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (latch_item)
        begin
            item_reg <= head.item;
        end
        if (latch_match)
        begin
            nochange_reg <= nochange_c;
            full_reg     <= full_c;
            s_idx_reg    <= s_idx_c;
            left_reg     <= key_l ? start_lb : item_reg.span_lo;
            right_reg    <= next_hit ? stop_se : item_reg.span_hi;
            next_oh_reg  <= oh_se;
            merged_reg   <= {1'b0, key_hit} + {1'b0, next_hit};
        end
        if (do_write && !nochange_reg && !full_reg)
        begin
            start_reg[s_idx_reg] <= left_reg;
            stop_reg[s_idx_reg]  <= right_reg;
        end
        if (do_write)
        begin
            ohas_reg   <= 1'b0;
            obegin_reg <= '0;
            oend_reg   <= '0;
            olast_reg  <= 1'b1;
            ofull_reg  <= full_reg && !nochange_reg;
        end
        else if (do_dump_emit)
        begin
            ohas_reg   <= 1'b1;
            obegin_reg <= dump_begin;
            oend_reg   <= dump_end;
            olast_reg  <= dump_last;
            ofull_reg  <= 1'b0;
        end
        else if (do_dump_clear)
        begin
            ohas_reg   <= 1'b0;
            obegin_reg <= '0;
            oend_reg   <= '0;
            olast_reg  <= 1'b1;
            ofull_reg  <= 1'b0;
        end
    end

    // the counter only moves on add write-back, so it is current at emit
    assign out_valid     = ovalid_reg;
    assign out_has_range = ohas_reg;
    assign out_begin     = obegin_reg;
    assign out_end       = oend_reg;
    assign out_last      = olast_reg;
    assign out_count     = count_reg;
    assign out_full      = ofull_reg;

endmodule
`default_nettype wire

### hdl/address_range_coalescer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// address_range_coalescer_core
// Coalescing table of address ranges with add and dump/clear requests.
// ----------------------------------------------------------------------------
// Add path: with the engine idle, a taken request moves through intake from
//   the queue and table match, then write-back into the output register.
// Engine occupancy: an add holds the table engine through intake, match and
//   write-back; a dump holds it through intake, then one emit per live entry
//   when reporting a non-empty table, else one clear result. Output stalls
//   hold the engine until the output register is free.
// Reset (rst_n, async, active low): table empty, counter zero,
//   report_on_dump cleared, queue and output register empty.
// ----------------------------------------------------------------------------
module address_range_coalescer_core
    import arc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // request stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,  // [47:0] span start, [95:48] span end
    input  wire logic [0:0]   s_axis_tuser,  // [0] kind
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [111:0]      m_axis_tdata,  // [47:0] out_begin, [95:48] out_end,
                                             // [111:96] range_count
    output logic [1:0]        m_axis_tuser,  // [0] has_range, [1] table_full
    output logic              m_axis_tlast,  // last
    // configuration
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [0:0]   cfg_data       // [0] report_on_dump
);

    item_t  in_item;
    head_t  head;
    logic   pop;
    logic   report_reg;
    logic   has_range, out_full;
    addr_t  out_begin, out_end;
    count_t out_count;

    // config register always writable; only changed while idle by contract
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            report_reg <= cfg_data[0];
        end
    end

    assign in_item.kind    = s_axis_tuser[0];
    assign in_item.span_lo = s_axis_tdata[47:0];
    assign in_item.span_hi = s_axis_tdata[95:48];

    // front: request queue so intake can run ahead of the table walk
    arc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .in_item       (in_item),
        .head          (head),
        .pop           (pop)
    );

    // back: match, merge, write-back, dump walk and output register
    arc_table u_table
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .report_on_dump (report_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_has_range  (has_range),
        .out_begin      (out_begin),
        .out_end        (out_end),
        .out_last       (m_axis_tlast),
        .out_count      (out_count),
        .out_full       (out_full)
    );

    assign m_axis_tdata = {out_count, out_end, out_begin};
    assign m_axis_tuser = {out_full, has_range};

endmodule
`default_nettype wire
